### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int REQ_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int REG_W   = 16;
   localparam int CSR_IDX_W = 2;

   // command codes
   localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_START = 3'd1;
   localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_WAIT    = 2'd1;

   localparam logic [REG_W-1:0]  REG_RESET_VALUE = 16'd100;
   localparam logic [BYTE_W-1:0] MSB_MASK        = 8'h80;

   typedef struct packed {
      logic [REG_W-1:0] half_len;   // never zero
      logic [REG_W-1:0] ack_len;    // never zero
   } cfg_type;

   typedef struct packed {
      logic              scl_release;
      logic              sda_release;
      logic              busy_res;
      logic              done_res;
      logic              got_ack;
      logic [BYTE_W-1:0] rx_byte;
   } rsp_type;

endpackage

### rtl/i2cm_ifs.sv
// ----------------------------------------------------------------------------
// i2cm_req_if / i2cm_rsp_if
// Valid/ready channels for tick items and tick results.
// ----------------------------------------------------------------------------
interface i2cm_req_if
   import i2cm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [BYTE_W-1:0] tx_byte;
   logic              send_ack;
   logic              sda_line;
   logic              scl_line;

   modport source (output valid, req_type, tx_byte, send_ack, sda_line, scl_line,
                   input ready);
   modport sink   (input valid, req_type, tx_byte, send_ack, sda_line, scl_line,
                   output ready);
endinterface

interface i2cm_rsp_if
   import i2cm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              scl_release;
   logic              sda_release;
   logic              busy_res;
   logic              done_res;
   logic              got_ack;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, scl_release, sda_release, busy_res, done_res,
                   got_ack, rx_byte, input ready);
   modport sink   (input valid, scl_release, sda_release, busy_res, done_res,
                   got_ack, rx_byte, output ready);
endinterface

### rtl/i2cm_csr.sv
// ----------------------------------------------------------------------------
// i2cm_csr
// Timing registers; a zero write behaves as one.
// ----------------------------------------------------------------------------
module i2cm_csr
   import i2cm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   logic [REG_W-1:0] half_ff, half_in;
   logic [REG_W-1:0] ackw_ff, ackw_in;

   always_comb begin
      half_in = half_ff;
      ackw_in = ackw_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_in = csr_wdata;
            CSR_ACK_WAIT:    ackw_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= REG_RESET_VALUE;
         ackw_ff <= REG_RESET_VALUE;
      end else begin
         half_ff <= half_in;
         ackw_ff <= ackw_in;
      end
   end

   assign cfg.half_len = (half_ff == '0) ? REG_W'(1) : half_ff;
   assign cfg.ack_len  = (ackw_ff == '0) ? REG_W'(1) : ackw_ff;

endmodule

### rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: phase, half-period timer and bit shifter, one tick per item.
// ----------------------------------------------------------------------------
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              tick,
   input  cfg_type           cfg,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [BYTE_W-1:0] tx_byte,
   input  logic              send_ack,
   input  logic              sda_line,
   input  logic              scl_line,
   output rsp_type           rsp_next
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_START   = 3'd1;
   localparam logic [2:0] PH_STOP    = 3'd2;
   localparam logic [2:0] PH_WRITE   = 3'd3;
   localparam logic [2:0] PH_STRETCH = 3'd4;
   localparam logic [2:0] PH_ACKWAIT = 3'd5;
   localparam logic [2:0] PH_READ    = 3'd6;

   localparam logic [2:0] STEP_0 = 3'd0;
   localparam logic [2:0] STEP_1 = 3'd1;
   localparam logic [2:0] STEP_2 = 3'd2;
   localparam logic [2:0] STEP_3 = 3'd3;
   localparam logic [2:0] STEP_4 = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        step_ff, step_in;
   logic [REG_W-1:0]  tick_ff, tick_in;
   logic [3:0]        bit_ff, bit_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [REG_W-1:0]  ackcnt_ff, ackcnt_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              ackch_ff, ackch_in;
   logic              ackres_ff, ackres_in;
   logic [BYTE_W-1:0] rx_ff, rx_in;
   logic              done;
   logic [REG_W-1:0]  tick_dec;
   logic [3:0]        bit_inc;
   logic [BYTE_W-1:0] shift_wr;
   logic [BYTE_W-1:0] shift_rd;
   logic [REG_W-1:0]  ackcnt_inc;

   assign tick_dec   = tick_ff - REG_W'(1);
   assign bit_inc    = bit_ff + 4'd1;
   assign shift_wr   = {shift_ff[BYTE_W-2:0], 1'b0};
   assign shift_rd   = {shift_ff[BYTE_W-2:0], sda_line};
   assign ackcnt_inc = ackcnt_ff + REG_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      ackcnt_in = ackcnt_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      ackch_in  = ackch_ff;
      ackres_in = ackres_ff;
      rx_in     = rx_ff;
      done      = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_type == REQ_START || req_type == REQ_STOP ||
                req_type == REQ_WRITE || req_type == REQ_READ) begin
               step_in = STEP_0;
               bit_in  = '0;
               tick_in = cfg.half_len;
               unique case (req_type)
                  REQ_START: begin
                     phase_in = PH_START;
                     sda_in   = 1'b1;
                  end
                  REQ_STOP: begin
                     phase_in = PH_STOP;
                     sda_in   = 1'b0;
                  end
                  REQ_WRITE: begin
                     phase_in = PH_WRITE;
                     shift_in = tx_byte;
                     sda_in   = |(tx_byte & MSB_MASK);
                  end
                  default: begin
                     phase_in = PH_READ;
                     ackch_in = send_ack;
                     shift_in = '0;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end
               endcase
            end
         end
         PH_STRETCH: begin
            if (scl_line) begin
               phase_in  = PH_ACKWAIT;
               ackcnt_in = '0;
            end
         end
         PH_ACKWAIT: begin
            if (!sda_line) begin
               ackres_in = 1'b1;
               done      = 1'b1;
            end else begin
               ackcnt_in = ackcnt_inc;
               if (ackcnt_inc >= cfg.ack_len) begin
                  ackres_in = 1'b0;
                  done      = 1'b1;
               end
            end
            if (done) begin
               scl_in = 1'b0;
            end
         end
         PH_START, PH_STOP, PH_WRITE, PH_READ: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               tick_in = cfg.half_len;
               unique case (phase_ff)
                  PH_START: begin
                     priority case (step_ff)
                        STEP_0: begin scl_in = 1'b1; step_in = STEP_1; end
                        STEP_1: begin sda_in = 1'b0; step_in = STEP_2; end
                        STEP_2: begin scl_in = 1'b0; step_in = STEP_3; end
                        default: done = 1'b1;
                     endcase
                  end
                  PH_STOP: begin
                     priority case (step_ff)
                        STEP_0: begin scl_in = 1'b1; step_in = STEP_1; end
                        STEP_1: begin sda_in = 1'b1; step_in = STEP_2; end
                        default: begin
                           scl_in = 1'b0;
                           sda_in = 1'b1;
                           done   = 1'b1;
                        end
                     endcase
                  end
                  PH_WRITE: begin
                     priority case (step_ff)
                        STEP_0: begin scl_in = 1'b1; step_in = STEP_1; end
                        STEP_1: begin scl_in = 1'b0; step_in = STEP_2; end
                        STEP_2: begin
                           bit_in   = bit_inc;
                           shift_in = shift_wr;
                           if (!bit_inc[3]) begin
                              sda_in  = |(shift_wr & MSB_MASK);
                              step_in = STEP_0;
                           end else begin
                              sda_in  = 1'b1;
                              step_in = STEP_3;
                           end
                        end
                        default: begin
                           scl_in   = 1'b1;
                           phase_in = PH_STRETCH;
                        end
                     endcase
                  end
                  default: begin
                     priority case (step_ff)
                        STEP_0: begin scl_in = 1'b1; step_in = STEP_1; end
                        STEP_1: begin
                           shift_in = shift_rd;
                           scl_in   = 1'b0;
                           bit_in   = bit_inc;
                           step_in  = bit_inc[3] ? STEP_2 : STEP_0;
                        end
                        STEP_2: begin sda_in = !ackch_ff; step_in = STEP_3; end
                        STEP_3: begin scl_in = 1'b1; step_in = STEP_4; end
                        default: begin
                           scl_in = 1'b0;
                           rx_in  = shift_ff;
                           done   = 1'b1;
                        end
                     endcase
                  end
               endcase
            end
         end
         default: ;
      endcase

      if (done) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         step_ff   <= STEP_0;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         ackcnt_ff <= '0;
         scl_ff    <= 1'b0;
         sda_ff    <= 1'b1;
         ackch_ff  <= 1'b0;
         ackres_ff <= 1'b0;
         rx_ff     <= '0;
      end else if (tick) begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         ackcnt_ff <= ackcnt_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         ackch_ff  <= ackch_in;
         ackres_ff <= ackres_in;
         rx_ff     <= rx_in;
      end
   end

   assign rsp_next.scl_release = scl_in;
   assign rsp_next.sda_release = sda_in;
   assign rsp_next.busy_res    = (phase_in != PH_IDLE);
   assign rsp_next.done_res    = done;
   assign rsp_next.got_ack     = ackres_in;
   assign rsp_next.rx_byte     = rx_in;

endmodule

### rtl/i2cm_out.sv
// ----------------------------------------------------------------------------
// i2cm_out
// Result register: holds one tick result until the sink takes it.
// ----------------------------------------------------------------------------
module i2cm_out
   import i2cm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type data_in,
   input  logic    take,
   output logic    valid,
   output rsp_type data_out
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign valid_in = load | (valid_ff & !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid    = valid_ff;
   assign data_out = data_ff;

endmodule

### rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master byte engine: start, stop, write byte, read byte.
//
//   channel   dir  transfer carries
//   req_bus   in   one bus tick: command, tx byte, ack choice, SCL/SDA levels
//   rsp_bus   out  one result per tick: line releases, busy, done, ack, rx byte
//   csr_*     in   timing register writes, no handshake
//
// Each tick item's result is registered in the result register; a new tick
// is taken every cycle unless rsp_bus stalls a waiting result. The result
// register is the only buffer: req_bus.ready drops only while a result waits
// and rsp_bus is stalled. Synchronous reset returns the sequencer to idle
// with SCL pulled low and SDA released, and both timing registers to 100.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   i2cm_req_if.sink             req_bus,
   i2cm_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_q;
   logic    rsp_valid;
   logic    tick;

   assign req_bus.ready = !rsp_valid || rsp_bus.ready;
   assign tick          = req_bus.valid && req_bus.ready;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .cfg      (cfg),
      .req_type (req_bus.req_type),
      .tx_byte  (req_bus.tx_byte),
      .send_ack (req_bus.send_ack),
      .sda_line (req_bus.sda_line),
      .scl_line (req_bus.scl_line),
      .rsp_next (rsp_next)
   );

   i2cm_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (tick),
      .data_in  (rsp_next),
      .take     (rsp_bus.ready),
      .valid    (rsp_valid),
      .data_out (rsp_q)
   );

   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.scl_release = rsp_q.scl_release;
   assign rsp_bus.sda_release = rsp_q.sda_release;
   assign rsp_bus.busy_res    = rsp_q.busy_res;
   assign rsp_bus.done_res    = rsp_q.done_res;
   assign rsp_bus.got_ack     = rsp_q.got_ack;
   assign rsp_bus.rx_byte     = rsp_q.rx_byte;

endmodule

### rtl/i2cm_chk.sv
// ----------------------------------------------------------------------------
// i2cm_chk
// Port-level checks of the byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic busy_res,
   input logic done_res
);

   // every accepted tick produces a result on the next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no result");

   // the input side never stalls while the result register is empty
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a completing tick reports not busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res)
      else $error("done reported while busy");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind i2c_master_byte_engine i2cm_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .busy_res  (rsp_bus.busy_res),
   .done_res  (rsp_bus.done_res)
);
